>>> hw/rtl/lzwc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZW compressor core.
// No dependencies; every other file of the block but lzwc_ram refers to this package.
package lzwc_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_CODE_W = 12;
  localparam int FIRST_CODE = 256;

  // Each slot of the hash table carries the epoch of the sequence that wrote it.
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef struct packed {
    logic req;
    logic flush;
  } dict_ctrl_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } dict_stat_t;

endpackage

>>> hw/rtl/lzwc_byte_if.sv
`timescale 1ns / 1ps
// Input channel of the LZW compressor: one byte and its last flag per item.
// Depends on lzwc_pkg for the byte width.
interface lzwc_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lzwc_pkg::BYTE_W-1:0] byte_value;
  logic                        last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> hw/rtl/lzwc_code_if.sv
`timescale 1ns / 1ps
// Output channel of the LZW compressor: one 12-bit code and its last flag per item.
// Depends on lzwc_pkg for the code width.
interface lzwc_code_if;
  logic                            valid;
  logic                            ready;
  logic [lzwc_pkg::OUT_CODE_W-1:0] code_value;
  logic                            last_code;

  modport source (output valid, output code_value, output last_code, input ready);
  modport sink   (input valid, input code_value, input last_code, output ready);
endinterface

>>> hw/rtl/lzwc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lzwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/lzwc_dict.sv
`timescale 1ns / 1ps
// Dictionary of the LZW compressor: a linear-probing hash table of
// (prefix, byte) -> code slots held in one lzwc_ram. Uses lzwc_pkg.
module lzwc_dict #(
  parameter int DICT_SIZE = 4096,
  localparam int CODE_W = $clog2(DICT_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lzwc_pkg::dict_ctrl_t        ctrl,
  input  logic [CODE_W-1:0]           prefix,
  input  logic [lzwc_pkg::BYTE_W-1:0] byte_value,
  output lzwc_pkg::dict_stat_t        stat,
  output logic [CODE_W-1:0]           code
);

  // The table has at least twice as many slots as the dictionary has codes,
  // so a probe chain always reaches a free slot.
  localparam int ADDR_W  = CODE_W + 1;
  localparam int KEY_W   = CODE_W + lzwc_pkg::BYTE_W;
  localparam int SLOT_W  = lzwc_pkg::EPOCH_W + KEY_W + CODE_W;
  localparam int NFREE_W = CODE_W + 1;
  localparam int DEPTH   = 2 ** ADDR_W;

  typedef enum logic [1:0] {D_CLEAR, D_IDLE, D_CHECK} dstate_t;

  dstate_t                       state;
  logic [lzwc_pkg::EPOCH_W-1:0]  epoch;
  logic [NFREE_W-1:0]            next_free;
  logic [ADDR_W-1:0]             probe_addr;
  logic [KEY_W-1:0]              key;
  logic                          flush;
  logic                          done;
  logic                          hit;
  logic [CODE_W-1:0]             code_q;

  logic [ADDR_W-1:0]             hash_addr;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [SLOT_W-1:0]             wr_data;
  logic [ADDR_W-1:0]             rd_addr;
  logic [SLOT_W-1:0]             rd_data;
  logic [lzwc_pkg::EPOCH_W-1:0]  slot_epoch;
  logic [KEY_W-1:0]              slot_key;
  logic [CODE_W-1:0]             slot_code;
  logic                          live;
  logic                          match;
  logic                          can_add;

  // Prefix codes spread over the low address bits, the byte folds into the top.
  assign hash_addr = ADDR_W'(prefix)
                   ^ (ADDR_W'(byte_value) << (ADDR_W - lzwc_pkg::BYTE_W));

  assign slot_epoch = rd_data[SLOT_W-1 -: lzwc_pkg::EPOCH_W];
  assign slot_key   = rd_data[CODE_W +: KEY_W];
  assign slot_code  = rd_data[CODE_W-1:0];

  // A slot written in an earlier sequence carries an older epoch and counts as free.
  assign live    = (slot_epoch == epoch);
  assign match   = live && (slot_key == key);
  assign can_add = (next_free < NFREE_W'(DICT_SIZE));

  always_comb begin
    rd_addr = hash_addr;
    wr_en   = 1'b0;
    wr_addr = probe_addr;
    wr_data = '0;
    case (state)
      D_CLEAR: begin
        wr_en = 1'b1;
        wr_data = {lzwc_pkg::EPOCH_NONE, KEY_W'(0), CODE_W'(0)};
      end
      D_IDLE: begin
        rd_addr = hash_addr;
      end
      D_CHECK: begin
        rd_addr = probe_addr + ADDR_W'(1);
        if (!live && can_add && !flush) begin
          wr_en = 1'b1;
          wr_data = {epoch, key, next_free[CODE_W-1:0]};
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  lzwc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= D_CLEAR;
      epoch      <= lzwc_pkg::EPOCH_FIRST;
      next_free  <= NFREE_W'(lzwc_pkg::FIRST_CODE);
      probe_addr <= '0;
      done       <= 1'b0;
      hit        <= 1'b0;
    end else begin
      done <= (state == D_CHECK) && (!live || match);
      case (state)
        D_CLEAR: begin
          probe_addr <= probe_addr + ADDR_W'(1);
          if (&probe_addr) begin
            state <= D_IDLE;
          end
        end
        D_IDLE: begin
          if (ctrl.req) begin
            key        <= {prefix, byte_value};
            flush      <= ctrl.flush;
            probe_addr <= hash_addr;
            state      <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (live && !match) begin
            probe_addr <= probe_addr + ADDR_W'(1);
          end else begin
            hit    <= match;
            code_q <= slot_code;
            if (flush) begin
              // End of sequence: retire every entry by moving to a new epoch.
              next_free <= NFREE_W'(lzwc_pkg::FIRST_CODE);
              if (epoch == lzwc_pkg::EPOCH_LAST) begin
                epoch      <= lzwc_pkg::EPOCH_FIRST;
                probe_addr <= '0;
                state      <= D_CLEAR;
              end else begin
                epoch <= epoch + lzwc_pkg::EPOCH_W'(1);
                state <= D_IDLE;
              end
            end else begin
              if (!live && can_add) begin
                next_free <= next_free + NFREE_W'(1);
              end
              state <= D_IDLE;
            end
          end
        end
        default: begin
          state <= D_CLEAR;
        end
      endcase
    end
  end

  assign stat.ready = (state == D_IDLE);
  assign stat.done  = done;
  assign stat.hit   = hit;
  assign code       = code_q;

endmodule

>>> hw/rtl/lzw_compressor_core.sv
`timescale 1ns / 1ps
// LZW compressor core. Takes one byte per item on byte_stream (last_byte marks
// the end of a sequence) and gives 12-bit codes on code_stream (last_code marks
// the final code of a sequence). Each sequence is coded with a fresh dictionary.
// Depends on lzwc_pkg, lzwc_byte_if, lzwc_code_if, lzwc_dict and lzwc_ram.
//
// The first byte of a sequence is absorbed in the cycle it is accepted. Every
// later byte needs a hash table lookup: the slot at the hash address is read,
// one more slot is read for each occupied slot of a colliding key, and the
// registered answer is then taken, with the byte's codes entering the output
// queue. No new byte is taken before the lookup of the last one is through,
// a limit set by the read-compare-write turn of the single table RAM.
//
// Codes wait in a four-item output queue. byte_stream.ready drops while the
// queue could not take the two codes one byte may produce, so a stalled
// receiver eventually stalls the sender and no code is lost.
// After reset, and after every fifteenth sequence of two or more bytes, the
// table is swept once: all 2 ** ($clog2(DICT_SIZE) + 1) slots (8192 at the
// default) are cleared while no bytes are taken.
module lzw_compressor_core #(
  parameter int DICT_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  lzwc_byte_if.sink   byte_stream,
  lzwc_code_if.source code_stream
);

  localparam int CODE_W     = $clog2(DICT_SIZE);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef enum logic {T_IDLE, T_WAIT} tstate_t;

  tstate_t                             state;
  logic                                prefix_present;
  logic [CODE_W-1:0]                   cur_prefix;
  logic [lzwc_pkg::BYTE_W-1:0]         item_byte;
  logic                                item_last;

  logic [lzwc_pkg::OUT_CODE_W-1:0]     q_code [FIFO_DEPTH];
  logic                                q_last [FIFO_DEPTH];
  logic [PTR_W-1:0]                    wr_ptr;
  logic [PTR_W-1:0]                    rd_ptr;
  logic [CNT_W-1:0]                    count;

  lzwc_pkg::dict_ctrl_t                dctrl;
  lzwc_pkg::dict_stat_t                dstat;
  logic [CODE_W-1:0]                   dcode;

  logic                                accept;
  logic                                pop;
  logic [1:0]                          n_push;
  logic [CODE_W-1:0]                   code_a;
  logic                                last_a;
  logic [CODE_W-1:0]                   code_b;
  logic [CODE_W-1:0]                   prefix_after;

  assign byte_stream.ready = (state == T_IDLE) && dstat.ready
                             && (count <= CNT_W'(FIFO_DEPTH - 2));
  assign accept = byte_stream.valid && byte_stream.ready;

  assign dctrl.req   = accept && prefix_present;
  assign dctrl.flush = byte_stream.last_byte;

  lzwc_dict #(
    .DICT_SIZE (DICT_SIZE)
  ) u_dict (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (dctrl),
    .prefix     (cur_prefix),
    .byte_value (byte_stream.byte_value),
    .stat       (dstat),
    .code       (dcode)
  );

  // Codes produced this cycle: a miss code and/or the final code of a sequence.
  always_comb begin
    n_push       = 2'd0;
    code_a       = cur_prefix;
    last_a       = 1'b0;
    code_b       = cur_prefix;
    prefix_after = cur_prefix;
    if (state == T_IDLE) begin
      if (accept && !prefix_present && byte_stream.last_byte) begin
        n_push = 2'd1;
        code_a = CODE_W'(byte_stream.byte_value);
        last_a = 1'b1;
      end
    end else if (dstat.done) begin
      if (dstat.hit) begin
        prefix_after = dcode;
        if (item_last) begin
          n_push = 2'd1;
          code_a = dcode;
          last_a = 1'b1;
        end
      end else begin
        prefix_after = CODE_W'(item_byte);
        n_push       = item_last ? 2'd2 : 2'd1;
        code_b       = CODE_W'(item_byte);
      end
    end
  end

  assign pop = code_stream.valid && code_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      prefix_present <= 1'b0;
      cur_prefix     <= '0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (n_push != 2'd0) begin
        q_code[wr_ptr] <= lzwc_pkg::OUT_CODE_W'(code_a);
        q_last[wr_ptr] <= last_a;
      end
      if (n_push == 2'd2) begin
        q_code[wr_ptr + PTR_W'(1)] <= lzwc_pkg::OUT_CODE_W'(code_b);
        q_last[wr_ptr + PTR_W'(1)] <= 1'b1;
      end
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(n_push) - CNT_W'(pop);

      case (state)
        T_IDLE: begin
          if (accept) begin
            item_byte <= byte_stream.byte_value;
            item_last <= byte_stream.last_byte;
            if (prefix_present) begin
              state <= T_WAIT;
            end else if (!byte_stream.last_byte) begin
              prefix_present <= 1'b1;
              cur_prefix     <= CODE_W'(byte_stream.byte_value);
            end
          end
        end
        T_WAIT: begin
          if (dstat.done) begin
            cur_prefix <= prefix_after;
            if (item_last) begin
              prefix_present <= 1'b0;
            end
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign code_stream.valid      = (count != '0);
  assign code_stream.code_value = q_code[rd_ptr];
  assign code_stream.last_code  = q_last[rd_ptr];

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("output queue holds more items than it has entries");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == T_WAIT))
    else $error("dictionary answered without an outstanding lookup");

  a_lookup_started: assert property (@(posedge clk) disable iff (rst)
    (accept && prefix_present) |=> ((state == T_WAIT) && !dstat.ready))
    else $error("accepted byte with a prefix did not start a lookup");

  a_wait_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == T_WAIT) && dstat.done) |=> ((state == T_IDLE) && (count != '0 || !item_last)))
    else $error("lookup result not taken or final code missing");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lzw_compressor_core: byte sequences go in, codes are checked
// against an in-bench LZW encoder. Depends on lzwc_pkg, lzwc_byte_if and lzwc_code_if.
module testbench;

  // A small dictionary lets the full-dictionary test fit in a short run.
  localparam int DICT_SIZE      = 512;
  localparam int RANDOM_ITEMS   = 360;
  localparam int FINAL_ITEMS    = 120;
  localparam int DRAIN_CYCLES   = 64;
  // Covers a full table sweep plus the longest probe chain, several times over.
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [lzwc_pkg::OUT_CODE_W-1:0] code;
    logic                            last;
  } code_item_t;

  typedef enum int {PAT_NARROW, PAT_WIDE, PAT_PERIODIC} byte_pattern_t;

  logic clk = 1'b0;
  logic rst;

  lzwc_byte_if byte_bus ();
  lzwc_code_if code_bus ();

  lzw_compressor_core #(.DICT_SIZE(DICT_SIZE)) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_bus),
    .code_stream (code_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Encoder state kept by the bench.
  logic [lzwc_pkg::OUT_CODE_W-1:0] dict_code [bit [lzwc_pkg::OUT_CODE_W+lzwc_pkg::BYTE_W-1:0]];
  logic [12:0]                     next_code = 13'(lzwc_pkg::FIRST_CODE);
  logic [lzwc_pkg::OUT_CODE_W-1:0] cur_prefix = '0;
  bit                              have_prefix = 1'b0;
  code_item_t                      pending_codes [$];

  bit         idle_on = 1'b1;
  int         errors = 0;
  int         quiet_cycles = 0;
  code_item_t want_code;

  function automatic void add_expected(input logic [lzwc_pkg::OUT_CODE_W-1:0] code,
                                       input logic lst);
    code_item_t item;
    item.code     = code;
    item.last     = lst;
    pending_codes = {pending_codes, item};
  endfunction

  function automatic void encode_byte(input logic [lzwc_pkg::BYTE_W-1:0] b, input logic lst);
    bit [lzwc_pkg::OUT_CODE_W+lzwc_pkg::BYTE_W-1:0] key;
    key = {cur_prefix, b};
    if (!have_prefix) begin
      cur_prefix  = lzwc_pkg::OUT_CODE_W'(b);
      have_prefix = 1'b1;
    end else if (dict_code.exists(key)) begin
      cur_prefix = dict_code[key];
    end else begin
      add_expected(cur_prefix, 1'b0);
      if (next_code < DICT_SIZE) begin
        dict_code[key] = next_code[lzwc_pkg::OUT_CODE_W-1:0];
        next_code      = next_code + 13'd1;
      end
      cur_prefix = lzwc_pkg::OUT_CODE_W'(b);
    end
    if (lst) begin
      add_expected(cur_prefix, 1'b1);
      have_prefix = 1'b0;
      cur_prefix  = '0;
      next_code   = 13'(lzwc_pkg::FIRST_CODE);
      dict_code.delete();
    end
  endfunction

  task automatic send_byte(input logic [lzwc_pkg::BYTE_W-1:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.byte_value <= b;
    byte_bus.last_byte  <= lst;
    do @(posedge clk); while (!byte_bus.ready);
    encode_byte(b, lst);
  endtask

  task automatic send_sequence(input int len, input byte_pattern_t pat);
    logic [lzwc_pkg::BYTE_W-1:0] base;
    logic [lzwc_pkg::BYTE_W-1:0] b;
    int                          period;
    base   = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
    period = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_NARROW: begin
          b = base + lzwc_pkg::BYTE_W'($urandom_range(0, 3));
        end
        PAT_WIDE: begin
          b = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
        end
        default: begin
          // A repeating phrase with an occasional stray byte builds long entries.
          if ($urandom_range(0, 15) == 0) b = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
          else b = base + lzwc_pkg::BYTE_W'((i % period) * 37);
        end
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic test_single_byte_sequences();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_repeated_byte_runs();
    for (int i = 0; i < 5; i++) send_byte(8'h00, i == 4);
    for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
  endtask

  task automatic test_text_phrase();
    logic [lzwc_pkg::BYTE_W-1:0] phrase [10];
    phrase = '{"T", "O", "B", "E", "O", "R", "T", "O", "B", "E"};
    foreach (phrase[i]) send_byte(phrase[i], i == 9);
  endtask

  task automatic test_dictionary_full();
    logic [lzwc_pkg::BYTE_W-1:0] opening [$];
    logic [lzwc_pkg::BYTE_W-1:0] b;
    while (next_code < DICT_SIZE) begin
      b = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
      if (opening.size() < 400) opening = {opening, b};
      send_byte(b, 1'b0);
    end
    // Replaying the opening bytes walks existing entries while nothing can be added.
    foreach (opening[i]) send_byte(opening[i], 1'b0);
    repeat (100) send_byte(lzwc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_sequences();
    int            sent;
    int            len;
    int            pick;
    byte_pattern_t pat;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      pick = $urandom_range(0, 9);
      pat  = (pick < 5) ? PAT_NARROW : (pick < 8) ? PAT_PERIODIC : PAT_WIDE;
      send_sequence(len, pat);
      sent += len;
    end
  endtask

  task automatic test_back_to_back();
    int len;
    int sent;
    idle_on = 1'b0;
    sent = 0;
    while (sent < FINAL_ITEMS) begin
      len = $urandom_range(1, 30);
      send_sequence(len, ($urandom_range(0, 1) == 0) ? PAT_NARROW : PAT_PERIODIC);
      sent += len;
    end
  endtask

  // Receiver side: ready drops in random bursts while idling is enabled.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    code_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        code_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        code_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        code_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && code_bus.valid && code_bus.ready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code: expected none, actual code %0d last %0b",
                 $time, code_bus.code_value, code_bus.last_code);
        errors++;
      end else begin
        want_code = pending_codes.pop_front();
        if (code_bus.code_value !== want_code.code) begin
          $display("%0t: code_value mismatch: expected %0d, actual %0d",
                   $time, want_code.code, code_bus.code_value);
          errors++;
        end
        if (code_bus.last_code !== want_code.last) begin
          $display("%0t: last_code mismatch: expected %0b, actual %0b",
                   $time, want_code.last, code_bus.last_code);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_bus.valid && byte_bus.ready) || (code_bus.valid && code_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                 <= 1'b1;
    byte_bus.valid      <= 1'b0;
    byte_bus.byte_value <= '0;
    byte_bus.last_byte  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_single_byte_sequences();
    test_repeated_byte_runs();
    test_text_phrase();
    test_dictionary_full();
    test_random_sequences();
    test_back_to_back();
    byte_bus.valid <= 1'b0;

    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> lzw_compressor_core.f
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_byte_if.sv
hw/rtl/lzwc_code_if.sv
hw/rtl/lzwc_ram.sv
hw/rtl/lzwc_dict.sv
hw/rtl/lzw_compressor_core.sv
test/testbench.sv
